// ----- design/assert_macros.svh -----
// assertion macros for the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property that must hold at every clock edge out of reset
`define PZB_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("pzb check failed");
// condition that must never be seen out of reset
`define PZB_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("pzb forbidden condition");
`else
`define PZB_ASSERT(lbl, prop)
`define PZB_NEVER(lbl, expr)
`endif
`endif

// ----- design/pzb_pkg.sv -----
// types, codes and defaults of the point z-buffer
package pzb_pkg;

	localparam int DEF_IMAGE_WIDTH   = 512;
	localparam int DEF_IMAGE_HEIGHT  = 512;
	localparam int DEF_SEARCH_RADIUS = 1;
	localparam int POINT_INDEX_BITS  = 20;
	localparam int CFG_REGS          = 8;
	localparam int CFG_INDEX_W       = 3;
	localparam int DIV_STEPS         = 32;

	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_POINT = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;

	localparam logic [2:0] STAT_STORED   = 3'd0;
	localparam logic [2:0] STAT_REJECT   = 3'd1;
	localparam logic [2:0] STAT_FOUND    = 3'd2;
	localparam logic [2:0] STAT_NOTFOUND = 3'd3;
	localparam logic [2:0] STAT_CLEARED  = 3'd4;

	typedef struct packed {
		logic [1:0]         command;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic [19:0]        point_id;
		logic [8:0]         pixel_x;
		logic [8:0]         pixel_y;
	} cmd_word_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [19:0] found_id;
	} res_word_t;

	// one pixel entry of the z-buffer memory
	typedef struct packed {
		logic                        occ;
		logic signed [31:0]          depth;
		logic [POINT_INDEX_BITS-1:0] idx;
	} pix_word_t;

	typedef enum logic [3:0] {
		S_SWEEP,
		S_IDLE,
		S_MUL,
		S_ACC,
		S_CHECK,
		S_DIV,
		S_DIVFIX,
		S_READ,
		S_UPD,
		S_QSCAN,
		S_DONE
	} pzb_state_t;

endpackage

// ----- design/point_zbuffer_neighbor_lookup.sv -----
// point cloud z-buffer with keypoint neighbourhood lookup
//
//  channel  direction  handshake               word
//  cfg      in         cfg_valid / cfg_ready   cfg_index, cfg_data (64 bit)
//  cmd      in         cmd_valid / cmd_ready   cmd (cmd_word_t)
//  res      out        res_valid / res_ready   res (res_word_t)
//
// one word in flight at a time; a point passes, in order, through the shared 32x32
//   multiplier over four dot products, a check, two serial divides, a read and a
//   write of the pixel memory, and a result load
// a query scans the neighbourhood ring by ring out to SEARCH_RADIUS, one pixel
//   memory read a cycle; a clear sweeps every pixel
// after reset the same sweep runs (no command taken)
// the result register frees the core, so a new word is taken while a result waits
`include "assert_macros.svh"
module point_zbuffer_neighbor_lookup import pzb_pkg::*; #(
	parameter int IMAGE_WIDTH   = DEF_IMAGE_WIDTH,
	parameter int IMAGE_HEIGHT  = DEF_IMAGE_HEIGHT,
	parameter int SEARCH_RADIUS = DEF_SEARCH_RADIUS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [63:0]            cfg_data,
	input  logic                   cmd_valid,
	output logic                   cmd_ready,
	input  cmd_word_t              cmd,
	output logic                   res_valid,
	input  logic                   res_ready,
	output res_word_t              res
);

	localparam int NPIX   = IMAGE_WIDTH * IMAGE_HEIGHT;
	localparam int ADDR_W = $clog2(NPIX);
	localparam int XB     = $clog2(IMAGE_WIDTH);
	localparam int YB     = $clog2(IMAGE_HEIGHT);
	localparam int CB     = (XB > YB) ? XB : YB;
	localparam int QW     = ((CB > 9) ? CB : 9) + 2;       // signed neighbour coordinate
	localparam int OW     = $clog2(SEARCH_RADIUS + 1) + 1; // signed ring offset
	localparam int PW     = $bits(pix_word_t);
	localparam logic signed [49:0] SAT_HI = 50'sd2147483647;
	localparam logic signed [49:0] SAT_LO = -50'sd2147483648;
	localparam logic signed [OW-1:0] RADIUS = OW'(SEARCH_RADIUS);

	pzb_state_t state_q, state_d;

	logic [63:0]        cfg_q [CFG_REGS];
	cmd_word_t          cmd_q;
	logic [2:0]         stat_q;
	logic [19:0]        fid_q;
	res_word_t          res_q;
	logic               res_valid_q;

	// pixel memory sweep
	logic [ADDR_W-1:0]  sweep_addr_q;
	logic               sweep_rep_q;

	// dot products over one shared multiplier
	logic [1:0]         r_q, t_q;
	logic signed [63:0] prod_q;
	logic signed [49:0] acc_q;
	logic signed [31:0] rowres_q [4];
	logic [63:0]        ra, rb;
	logic signed [31:0] coef, coord;
	logic signed [49:0] row_sum;
	logic signed [31:0] row_sat;

	// serial divider
	logic               dsel_q, dneg_q, range_ok_q;
	logic [31:0]        dq_q, den_q;
	logic [32:0]        dr_q;
	logic [4:0]         dcnt_q;
	logic [32:0]        rem_sh;
	logic signed [33:0] q_mag, q_fix;
	logic               q_in_range;
	logic [XB-1:0]      col_q;
	logic [YB-1:0]      row_q;

	// neighbourhood scan
	logic signed [OW-1:0] mn_q, dk_q, dl_q;
	logic               qdone_q, qv_s1, q_last;
	logic signed [QW-1:0] qk, ql;
	logic               q_in_img;
	logic [ADDR_W-1:0]  q_addr, pix_addr;

	// pixel memory port
	logic               ram_we, ram_re, pix_write;
	logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
	pix_word_t          ram_wdata, ram_rdata;
	logic [PW-1:0]      rdata_raw;

	logic signed [31:0] u_val, v_val, w_val, d_val;
	logic               out_load;

	function automatic logic [31:0] mag32(input logic signed [31:0] a);
		mag32 = a[31] ? (~a + 32'd1) : a;
	endfunction

	assign u_val = rowres_q[0];
	assign v_val = rowres_q[1];
	assign w_val = rowres_q[2];
	assign d_val = rowres_q[3];

	pzb_ram #(
		.WIDTH (PW),
		.DEPTH (NPIX)
	) u_pix_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rdata_raw)
	);
	assign ram_rdata = pix_word_t'(rdata_raw);

	// coefficient and coordinate for the current product
	always_comb begin
		unique case (r_q)
			2'd0: begin ra = cfg_q[0]; rb = cfg_q[1]; end
			2'd1: begin ra = cfg_q[2]; rb = cfg_q[3]; end
			2'd2: begin ra = cfg_q[4]; rb = cfg_q[5]; end
			default: begin ra = cfg_q[6]; rb = cfg_q[7]; end
		endcase
		unique case (t_q)
			2'd0: begin coef = ra[31:0];  coord = cmd_q.point_x; end
			2'd1: begin coef = ra[63:32]; coord = cmd_q.point_y; end
			default: begin coef = rb[31:0]; coord = cmd_q.point_z; end
		endcase
	end

	// floored product, plus the offset on the last term, then saturation
	always_comb begin
		row_sum = acc_q + {{2{prod_q[63]}}, prod_q[63:16]};
		if (t_q == 2'd2) begin
			row_sum = row_sum + {{18{rb[63]}}, rb[63:32]};
		end
		if (row_sum > SAT_HI) begin
			row_sat = 32'sh7FFF_FFFF;
		end else if (row_sum < SAT_LO) begin
			row_sat = -32'sh8000_0000;
		end else begin
			row_sat = row_sum[31:0];
		end
	end

	// divider step and floor correction of the quotient
	always_comb begin
		rem_sh     = {dr_q[31:0], dq_q[31]};
		q_mag      = {2'b00, dq_q};
		q_fix      = dneg_q ? (-q_mag - {33'd0, (dr_q != 33'd0)}) : q_mag;
		q_in_range = !q_fix[33] &&
			(q_fix[32:0] < (dsel_q ? 33'(IMAGE_HEIGHT) : 33'(IMAGE_WIDTH)));
	end

	// neighbour under test
	always_comb begin
		qk       = $signed({{(QW-9){1'b0}}, cmd_q.pixel_x}) + QW'(dk_q);
		ql       = $signed({{(QW-9){1'b0}}, cmd_q.pixel_y}) + QW'(dl_q);
		q_in_img = !qk[QW-1] && !ql[QW-1] &&
			(qk < $signed(QW'(IMAGE_WIDTH))) && (ql < $signed(QW'(IMAGE_HEIGHT)));
		q_addr   = ADDR_W'(ql[YB-1:0]) * ADDR_W'(IMAGE_WIDTH) + ADDR_W'(qk[XB-1:0]);
		q_last   = (mn_q == RADIUS) && (dk_q == mn_q) && (dl_q == mn_q);
		pix_addr = ADDR_W'(row_q) * ADDR_W'(IMAGE_WIDTH) + ADDR_W'(col_q);
	end

	assign pix_write = !ram_rdata.occ || (d_val < ram_rdata.depth);
	assign out_load  = !res_valid_q || res_ready;

	// next state and memory port
	always_comb begin
		state_d   = state_q;
		cmd_ready = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = pix_addr;
		ram_raddr = pix_addr;
		ram_wdata = '{occ: 1'b1, depth: d_val, idx: cmd_q.point_id};
		unique case (state_q)
			S_SWEEP: begin
				ram_we    = 1'b1;
				ram_waddr = sweep_addr_q;
				ram_wdata = '0;
				if (sweep_addr_q == ADDR_W'(NPIX - 1)) begin
					state_d = sweep_rep_q ? S_DONE : S_IDLE;
				end
			end
			S_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					unique case (cmd.command)
						CMD_CLEAR: state_d = S_SWEEP;
						CMD_POINT: state_d = S_MUL;
						CMD_QUERY: state_d = S_QSCAN;
						default:   state_d = S_DONE;
					endcase
				end
			end
			S_MUL: state_d = S_ACC;
			S_ACC: begin
				state_d = (r_q == 2'd3 && t_q == 2'd2) ? S_CHECK : S_MUL;
			end
			S_CHECK: begin
				// zero divisor or depth not in front of the camera
				if (w_val == 32'sd0 || d_val <= 32'sd0) begin
					state_d = S_DONE;
				end else begin
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				if (dcnt_q == 5'(DIV_STEPS - 1)) begin
					state_d = S_DIVFIX;
				end
			end
			S_DIVFIX: begin
				if (!dsel_q) begin
					state_d = S_DIV;
				end else begin
					state_d = (range_ok_q && q_in_range) ? S_READ : S_DONE;
				end
			end
			S_READ: begin
				ram_re  = 1'b1;
				state_d = S_UPD;
			end
			S_UPD: begin
				ram_we  = pix_write;
				state_d = S_DONE;
			end
			S_QSCAN: begin
				ram_raddr = q_addr;
				priority if (qv_s1 && ram_rdata.occ) begin
					state_d = S_DONE;
				end else if (qdone_q && !qv_s1) begin
					state_d = S_DONE;
				end else begin
					ram_re = !qdone_q && q_in_img;
				end
			end
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers, written only while idle
	assign cfg_ready = (state_q == S_IDLE);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CFG_REGS; i++) begin
				cfg_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_addr_q <= '0;
			sweep_rep_q  <= 1'b0;
			r_q          <= '0;
			t_q          <= '0;
			dcnt_q       <= '0;
			dsel_q       <= 1'b0;
			qdone_q      <= 1'b0;
			qv_s1        <= 1'b0;
		end else begin
			unique case (state_q)
				S_SWEEP: sweep_addr_q <= sweep_addr_q + 1'b1;
				S_IDLE: begin
					sweep_addr_q <= '0;
					sweep_rep_q  <= 1'b1;
					r_q          <= '0;
					t_q          <= '0;
					qdone_q      <= 1'b0;
					qv_s1        <= 1'b0;
				end
				S_ACC: begin
					if (t_q == 2'd2) begin
						t_q <= '0;
						r_q <= r_q + 1'b1;
					end else begin
						t_q <= t_q + 1'b1;
					end
				end
				S_CHECK: begin
					dcnt_q <= '0;
					dsel_q <= 1'b0;
				end
				S_DIV: dcnt_q <= dcnt_q + 1'b1;
				S_DIVFIX: begin
					dcnt_q <= '0;
					dsel_q <= 1'b1;
				end
				S_QSCAN: begin
					if (!(qv_s1 && ram_rdata.occ)) begin
						qv_s1 <= !qdone_q && q_in_img;
						if (!qdone_q) begin
							qdone_q <= q_last;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				cmd_q  <= cmd;
				acc_q  <= '0;
				mn_q   <= '0;
				dk_q   <= '0;
				dl_q   <= '0;
				fid_q  <= '0;
				stat_q <= (cmd.command == CMD_CLEAR) ? STAT_CLEARED : STAT_REJECT;
			end
			S_MUL: prod_q <= coef * coord;
			S_ACC: begin
				if (t_q == 2'd2) begin
					rowres_q[r_q] <= row_sat;
					acc_q         <= '0;
				end else begin
					acc_q <= row_sum;
				end
			end
			S_CHECK: begin
				dq_q       <= mag32(u_val);
				den_q      <= mag32(w_val);
				dneg_q     <= u_val[31] ^ w_val[31];
				dr_q       <= '0;
				range_ok_q <= 1'b1;
			end
			S_DIV: begin
				// one restoring step per cycle
				if (rem_sh >= {1'b0, den_q}) begin
					dr_q <= rem_sh - {1'b0, den_q};
					dq_q <= {dq_q[30:0], 1'b1};
				end else begin
					dr_q <= rem_sh;
					dq_q <= {dq_q[30:0], 1'b0};
				end
			end
			S_DIVFIX: begin
				if (!dsel_q) begin
					col_q      <= q_fix[XB-1:0];
					range_ok_q <= q_in_range;
					dq_q       <= mag32(v_val);
					dneg_q     <= v_val[31] ^ w_val[31];
					dr_q       <= '0;
				end else begin
					row_q <= q_fix[YB-1:0];
				end
			end
			S_UPD: begin
				if (pix_write) begin
					stat_q <= STAT_STORED;
				end
			end
			S_QSCAN: begin
				priority if (qv_s1 && ram_rdata.occ) begin
					stat_q <= STAT_FOUND;
					fid_q  <= 20'(ram_rdata.idx);
				end else if (qdone_q && !qv_s1) begin
					stat_q <= STAT_NOTFOUND;
				end else if (!qdone_q) begin
					// column outer, row inner, square grows by one each ring
					if (dl_q != mn_q) begin
						dl_q <= dl_q + 1'b1;
					end else if (dk_q != mn_q) begin
						dk_q <= dk_q + 1'b1;
						dl_q <= -mn_q;
					end else begin
						mn_q <= mn_q + 1'b1;
						dk_q <= -(mn_q + 1'b1);
						dl_q <= -(mn_q + 1'b1);
					end
				end
			end
			S_DONE: begin
				if (out_load) begin
					res_q <= '{status: stat_q, found_id: fid_q};
				end
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	`PZB_ASSERT(a_one_in_flight, (cmd_valid && cmd_ready) |=> !cmd_ready)
	`PZB_NEVER(a_write_state, ram_we && !(state_q == S_SWEEP || state_q == S_UPD))
	`PZB_NEVER(a_found_id_zero, res_valid && res.status != STAT_FOUND && res.found_id != 20'd0)
	`PZB_NEVER(a_read_write_clash, ram_we && ram_re)

endmodule

// ----- design/pzb_ram.sv -----
// generic single-write, single-read ram with registered read data
module pzb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
